// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the square root unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property that is ignored while reset is applied.
`define FSRU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked property that also holds while reset is applied.
`define FSRU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/fsru_pkg.sv -----
// Package with constants, types and step functions of the square root unit.
`timescale 1ns / 1ps
package fsru_pkg;

	localparam int unsigned CORE_STEPS = 13;

	// Position of each pipeline stage in the valid vector.
	localparam int unsigned ST_DEC = 0;
	localparam int unsigned ST_MUL = CORE_STEPS + 1;
	localparam int unsigned ST_SQ  = CORE_STEPS + 2;
	localparam int unsigned ST_RND = CORE_STEPS + 3;
	localparam int unsigned ST_OUT = CORE_STEPS + 4;
	localparam int unsigned NUM_ST = CORE_STEPS + 5;

	localparam logic [31:0] QNAN_BITS    = 32'h7FC0_0001;
	localparam logic [31:0] POS_INF_BITS = 32'h7F80_0000;
	localparam logic [31:0] NEG_INF_BITS = 32'hFF80_0000;
	localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;
	localparam logic [31:0] RSQRT_SEED   = 32'h4000_0000;
	localparam logic [13:0] RSQRT_LIMIT  = 14'h0200;
	localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;

	typedef struct packed {
		logic        spec;
		logic [31:0] spec_res;
		logic        mode;
		logic [7:0]  ex;
		logic [24:0] sig;
	} meta_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
	} xy_t;

	typedef struct packed {
		meta_t       meta;
		logic [31:0] x;
		logic [31:0] y;
	} core_t;

	// Leading zero count of a 23-bit fraction.
	function automatic logic [4:0] lzc23(logic [22:0] v);
		logic [4:0] n;
		logic       found;
		n = '0;
		found = 1'b0;
		for (int i = 22; i >= 0; i--) begin
			if (!found) begin
				if (v[i]) found = 1'b1;
				else n = n + 5'd1;
			end
		end
		return n;
	endfunction

	// First normalization step: two factors of 1.5, taken only together.
	function automatic xy_t core_first(logic [31:0] x, logic [31:0] y);
		logic [31:0] t;
		logic [31:0] t2;
		xy_t         r;
		r.x = x;
		r.y = y;
		t = x + (x >> 1);
		t2 = t + (t >> 1);
		if (t < SIGN_BIT && t2 < SIGN_BIT) begin
			r.x = t2;
			r.y = y + (y >> 1);
		end
		return r;
	endfunction

	// Normalization step i: x gains (1 + 2^-i)^2, y gains (1 + 2^-i).
	function automatic xy_t core_step(logic [31:0] x, logic [31:0] y, int unsigned i);
		logic [31:0] t;
		xy_t         r;
		r.x = x;
		r.y = y;
		t = x + (x >> i);
		t = t + (t >> i);
		if (t < SIGN_BIT) begin
			r.x = t;
			r.y = y + (y >> i);
		end
		return r;
	endfunction

endpackage

// ----- src/float32_sqrt_rsqrt_unit.sv -----
// Top level of the single precision square root and reciprocal square root unit.
// An accepted input word passes the decode, normalization, multiply, square, rounding and output stages.
// Throughput: one word per cycle while the output is not stalled; the 13 normalization steps each own a pipeline stage.
// Stages with no valid word fill in while the output is stalled, so bubbles collapse.
// Reset (arst_n low, asynchronous) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
module float32_sqrt_rsqrt_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [31:0] operand_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_bits
);
	`include "assert_macros.svh"

	localparam int unsigned NST = fsru_pkg::NUM_ST;
	localparam int unsigned CS  = fsru_pkg::CORE_STEPS;

	// One valid bit per stage; adv says that a stage loads in this cycle.
	logic [NST-1:0] vld_q;
	logic [NST-1:0] adv;

	// A stage may load when it is empty or when its word moves on.
	always_comb begin
		adv[NST-1] = !vld_q[NST-1] || !out_stall;
		for (int k = NST - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_stall  = !adv[fsru_pkg::ST_DEC];
	assign out_valid = vld_q[fsru_pkg::ST_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: classify the operand, normalize subnormals and form the
	// result exponent. Zero, infinity, NaN and negative operands get
	// their final word here and just ride along.
	// ---------------------------------------------------------------
	fsru_pkg::meta_t dec;
	logic [7:0]         field;
	logic [4:0]         sh;
	logic signed [9:0]  e;
	logic signed [9:0]  half;
	logic [23:0]        sig24;

	always_comb begin
		field = operand_bits[30:23];
		sh = fsru_pkg::lzc23(operand_bits[22:0]) + 5'd1;
		dec.mode = mode;
		dec.spec = 1'b1;
		dec.spec_res = fsru_pkg::QNAN_BITS;
		if (operand_bits[31]) begin
			if (operand_bits == fsru_pkg::SIGN_BIT) begin
				dec.spec_res = mode ? fsru_pkg::NEG_INF_BITS : fsru_pkg::SIGN_BIT;
			end
		end else if (field == fsru_pkg::EXP_ALL_ONES) begin
			if (operand_bits == fsru_pkg::POS_INF_BITS) begin
				dec.spec_res = mode ? 32'd0 : fsru_pkg::POS_INF_BITS;
			end
		end else if (operand_bits == 32'd0) begin
			dec.spec_res = mode ? fsru_pkg::POS_INF_BITS : 32'd0;
		end else begin
			dec.spec = 1'b0;
		end
		if (field != 8'd0) begin
			sig24 = {1'b1, operand_bits[22:0]};
			e = $signed({2'b00, field}) - 10'sd127;
		end else begin
			sig24 = {1'b0, operand_bits[22:0]} << sh;
			e = -10'sd126 - $signed({5'b00000, sh});
		end
		// An odd exponent moves one factor of two into the significand.
		dec.sig = e[0] ? {sig24, 1'b0} : {1'b0, sig24};
		half = e >>> 1;
		dec.ex = mode ? 8'(10'sd125 - half) : 8'(half + 10'sd126);
	end

	fsru_pkg::meta_t meta_s1;
	always_ff @(posedge clk) begin
		if (adv[fsru_pkg::ST_DEC]) meta_s1 <= dec;
	end

	// ---------------------------------------------------------------
	// Stages 2 to 14: multiplicative normalization. x is driven toward
	// 2^31 while y collects the matching factors, one step per stage.
	// Square root seeds y with the significand, the reciprocal with 1.0.
	// ---------------------------------------------------------------
	fsru_pkg::core_t core_s [1:CS];
	fsru_pkg::xy_t   first_xy;
	logic [31:0]     x0;
	logic [31:0]     y0;

	always_comb begin
		x0 = {1'b0, meta_s1.sig, 6'd0};
		y0 = meta_s1.mode ? fsru_pkg::RSQRT_SEED : {meta_s1.sig, 7'd0};
		first_xy = fsru_pkg::core_first(x0, y0);
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			core_s[1].meta <= meta_s1;
			core_s[1].x <= first_xy.x;
			core_s[1].y <= first_xy.y;
		end
	end

	for (genvar k = 2; k <= CS; k++) begin : g_core
		fsru_pkg::xy_t nxt;
		assign nxt = fsru_pkg::core_step(core_s[k-1].x, core_s[k-1].y, k);
		always_ff @(posedge clk) begin
			if (adv[k]) begin
				core_s[k].meta <= core_s[k-1].meta;
				core_s[k].x <= nxt.x;
				core_s[k].y <= nxt.y;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 15: multiply correction, y * 1.5 - hi(x * y).
	// ---------------------------------------------------------------
	logic [63:0]     xy_prod;
	logic [31:0]     y2;
	fsru_pkg::meta_t meta_s15;
	logic [31:0]     y2_s15;

	always_comb begin
		xy_prod = 64'(core_s[CS].x) * 64'(core_s[CS].y);
		y2 = core_s[CS].y + (core_s[CS].y >> 1) - xy_prod[63:32];
	end

	always_ff @(posedge clk) begin
		if (adv[fsru_pkg::ST_MUL]) begin
			meta_s15 <= core_s[CS].meta;
			y2_s15 <= y2;
		end
	end

	// ---------------------------------------------------------------
	// Stage 16: square the estimates of both modes.
	// ---------------------------------------------------------------
	logic [23:0]     m;
	logic [25:0]     u;
	fsru_pkg::meta_t meta_s16;
	logic [23:0]     m_s16;
	logic [47:0]     sq_s16;
	logic [25:0]     u_s16;
	logic [51:0]     a_s16;

	assign m = y2_s15[31:8];
	assign u = y2_s15[31:6] | 26'd1;

	always_ff @(posedge clk) begin
		if (adv[fsru_pkg::ST_SQ]) begin
			meta_s16 <= meta_s15;
			m_s16 <= m;
			sq_s16 <= 48'(m) * 48'(m);
			u_s16 <= u;
			a_s16 <= 52'(u) * 52'(u);
		end
	end

	// ---------------------------------------------------------------
	// Stage 17: square root rounds on the residual sig * 2^23 - m^2;
	// the reciprocal forms the two partial products of sig * u^2.
	// ---------------------------------------------------------------
	logic signed [49:0] resid;
	logic               bump;
	logic [56:0]        blo_prod;
	fsru_pkg::meta_t    meta_s17;
	logic [24:0]        mfin_s17;
	logic [24:0]        bh_s17;
	logic [44:0]        b2_s17;
	logic [25:0]        u_s17;

	always_comb begin
		resid = $signed({2'b00, meta_s16.sig, 23'd0}) - $signed({2'b00, sq_s16});
		bump = resid > $signed({26'd0, m_s16});
		blo_prod = 57'(meta_s16.sig) * 57'(a_s16[31:0]);
	end

	always_ff @(posedge clk) begin
		if (adv[fsru_pkg::ST_RND]) begin
			meta_s17 <= meta_s16;
			mfin_s17 <= {1'b0, m_s16} + {24'd0, bump};
			bh_s17 <= blo_prod[56:32];
			b2_s17 <= 45'(meta_s16.sig) * 45'(a_s16[51:32]);
			u_s17 <= u_s16;
		end
	end

	// ---------------------------------------------------------------
	// Stage 18: reciprocal rounding, exponent merge and special-case
	// select into the output register.
	// ---------------------------------------------------------------
	logic [45:0] s_sum;
	logic [26:0] u_rnd;
	logic [31:0] rsig;
	logic [31:0] ex_field;
	logic [31:0] res;
	logic [31:0] res_s18;

	always_comb begin
		s_sum = {21'd0, bh_s17} + {1'b0, b2_s17};
		u_rnd = (s_sum[45:32] >= fsru_pkg::RSQRT_LIMIT) ? {1'b0, u_s17}
		                                                 : ({1'b0, u_s17} + 27'd1);
		rsig = {6'd0, u_rnd[26:1]};
		ex_field = {1'b0, meta_s17.ex, 23'd0};
		if (meta_s17.spec) begin
			res = meta_s17.spec_res;
		end else if (meta_s17.mode) begin
			res = rsig + ex_field;
		end else begin
			res = {7'd0, mfin_s17} + ex_field;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[fsru_pkg::ST_OUT]) res_s18 <= res;
	end

	assign result_bits = res_s18;

	// The input can only back up when the whole pipeline is full and the output is stalled.
	`FSRU_ASSERT(a_stall_full, in_stall |-> (out_valid && out_stall), "input stalled with room")
	// A word in the last rounding stage reaches an empty output register at once.
	`FSRU_ASSERT(a_fill_out, (vld_q[fsru_pkg::ST_RND] && !out_valid) |=> out_valid, "bubble kept")
	// A held decode word keeps its contents.
	`FSRU_ASSERT(a_hold_dec, (vld_q[0] && !adv[0]) |=> (vld_q[0] && $stable(meta_s1)), "decode lost")
	// No result word is shown while reset is applied.
	`FSRU_ASSERT_ALWAYS(a_rst_out, !arst_n |-> !out_valid, "valid during reset")

endmodule

// ----- dv/fsru_checker.sv -----
// Checker that predicts square root and reciprocal square root results and compares them.
`timescale 1ns / 1ps
module fsru_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        mode,
	input  logic [31:0] operand_bits,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] result_bits,
	output int          fail_count,
	output int          pending_count,
	output int          result_count
);
	logic [31:0] expected_results[$];

	function automatic logic [31:0] normalize_mul(logic [31:0] x_in, logic [31:0] y_in);
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] t;
		logic [31:0] hi;
		logic [63:0] prod;
		x = x_in << 6;
		y = y_in;
		t = x + (x >> 1);
		if (t < fsru_pkg::SIGN_BIT) begin
			t = t + (t >> 1);
			if (t < fsru_pkg::SIGN_BIT) begin
				x = t;
				y = y + (y >> 1);
			end
		end
		for (int i = 2; i <= fsru_pkg::CORE_STEPS; i++) begin
			t = x + (x >> i);
			t = t + (t >> i);
			if (t < fsru_pkg::SIGN_BIT) begin
				x = t;
				y = y + (y >> i);
			end
		end
		prod = {32'd0, x} * {32'd0, y};
		hi = prod[63:32];
		y = y + (y >> 1);
		return y - hi;
	endfunction

	function automatic logic [31:0] root_significand(logic [31:0] x);
		logic [31:0] m;
		longint sq;
		longint res;
		m = normalize_mul(x, x << 7) >> 8;
		sq = longint'(m) * longint'(m);
		res = longint'(x) * 64'sd8388608 - sq;
		if (res > longint'(m)) m = m + 32'd1;
		return m;
	endfunction

	function automatic logic [31:0] inv_root_significand(logic [31:0] y);
		logic [31:0] u;
		logic [63:0] a;
		logic [63:0] b_hi;
		logic [63:0] s;
		logic [31:0] p;
		u = (normalize_mul(y, fsru_pkg::RSQRT_SEED) >> 6) | 32'd1;
		a = {32'd0, u} * {32'd0, u};
		b_hi = ({32'd0, y} * {32'd0, a[31:0]}) >> 32;
		s = b_hi + {32'd0, y} * {32'd0, a[63:32]};
		p = s[63:32];
		return (p >= 32'h200) ? (u >> 1) : ((u + 32'd1) >> 1);
	endfunction

	function automatic logic [31:0] predict_result(logic inv, logic [31:0] bits);
		logic [7:0]  field;
		logic [31:0] sig;
		int          e;
		int          half;
		int          sh;
		field = bits[30:23];
		if (bits[31]) begin
			if (bits == fsru_pkg::SIGN_BIT)
				return inv ? fsru_pkg::NEG_INF_BITS : fsru_pkg::SIGN_BIT;
			return fsru_pkg::QNAN_BITS;
		end
		if (field == fsru_pkg::EXP_ALL_ONES) begin
			if (bits == fsru_pkg::POS_INF_BITS) return inv ? 32'd0 : fsru_pkg::POS_INF_BITS;
			return fsru_pkg::QNAN_BITS;
		end
		if (bits == 0) return inv ? fsru_pkg::POS_INF_BITS : 32'd0;
		if (field != 0) begin
			sig = {9'd0, bits[22:0]} + 32'h80_0000;
			e = int'(field) - 127;
		end else begin
			sh = 0;
			while (!bits[31 - sh]) sh++;
			sh = sh - 8;
			sig = bits << sh;
			e = -126 - sh;
		end
		if (e[0]) sig = sig << 1;
		half = e >>> 1;
		if (inv) return inv_root_significand(sig) + (32'(125 - half) << 23);
		return root_significand(sig) + (32'(half + 126) << 23);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %08h expected %08h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	assign pending_count = expected_results.size();

	always @(posedge clk) begin
		if (!arst_n) begin
			fail_count = 0;
			result_count = 0;
			expected_results.delete();
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(predict_result(mode, operand_bits));
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_results.size() == 0)
					report_mismatch("unexpected word", result_bits, 32'd0);
				else begin
					if (result_bits !== expected_results[0])
						report_mismatch("result_bits", result_bits, expected_results[0]);
					void'(expected_results.pop_front());
				end
			end
		end
	end
endmodule

// ----- dv/tb_top.sv -----
// Top of the testbench: clock, reset, stimulus and verdict for the square root unit.
`timescale 1ns / 1ps
module tb_top;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        mode;
	logic [31:0] operand_bits;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] result_bits;
	int          fail_count;
	int          pending_count;
	int          result_count;
	int          cycle_count;
	// Percent chance per cycle that the sender or the receiver idles.
	int          send_idle_pct;
	int          recv_idle_pct;
	int          sent_count;

	float32_sqrt_rsqrt_unit DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .operand_bits(operand_bits), .out_valid(out_valid),
		.out_stall(out_stall), .result_bits(result_bits)
	);

	fsru_checker checker_inst (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .operand_bits(operand_bits), .out_valid(out_valid),
		.out_stall(out_stall), .result_bits(result_bits), .fail_count(fail_count),
		.pending_count(pending_count), .result_count(result_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The cycle counter stops a hung run. The slowest legal run is roughly
	// 1300 words with their random stalls, so this limit is far above it.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 200000) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// The receiver stalls at random; the decision is made at the falling edge
	// so it is stable around every rising edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Random operand that favors the interesting corners of binary32.
	function automatic logic [31:0] random_operand();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(9))
			0: v[30:23] = 8'h00;
			1: v[30:23] = 8'hFF;
			2: v[30:23] = 8'hFE;
			3: v[30:23] = 8'h01;
			4: v[22:0] = (v[0]) ? 23'h7F_FFFF : 23'h0;
			5, 6, 7: v[31] = 1'b0;
			default: ;
		endcase
		return v;
	endfunction

	// Presents one word from the falling edge and holds it until accepted.
	// The valid stays high afterwards; the caller drops it before a pause.
	task automatic send_word(logic m, logic [31:0] bits);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		operand_bits <= bits;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		sent_count++;
	endtask

	logic [31:0] directed_ops [16] = '{
		32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
		32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h0000_0001,
		32'h007F_FFFF, 32'h0040_0000, 32'h0080_0000, 32'h7F7F_FFFF,
		32'h3F80_0000, 32'h4080_0000, 32'h4000_0000, 32'hBF80_0000
	};

	initial begin
		sent_count = 0;
		arst_n = 1'b1;
		in_valid = 1'b0;
		mode = 1'b0;
		operand_bits = 32'd0;
		send_idle_pct = 12;
		recv_idle_pct = 84;
		#1 arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words: zeros of both signs, infinities, NaNs, negatives,
		// subnormal extremes, the largest normal and a few exact squares.
		foreach (directed_ops[i]) begin
			send_word(1'b0, directed_ops[i]);
			send_word(1'b1, directed_ops[i]);
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 84 : 0;
			recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 12 : 0;
			for (int n = 0; n < 430; n++) begin
				// Midway through the first phase the sender holds off until the
				// pipeline has drained completely.
				if (phase == 0 && n == 200) begin
					in_valid <= 1'b0;
					@(negedge clk);
					while (pending_count != 0) @(negedge clk);
				end
				send_word(1'(($urandom)), random_operand());
			end
		end

		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_count != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		$display("Sent %0d words in both modes across three idling phases; %0d results checked.",
			sent_count, result_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
